// ===== hw/rtl/chunked_body_decoder_macros.svh =====
// Assertion macros used by the chunked body decoder back end.
`ifndef CHUNKED_BODY_DECODER_MACROS_SVH
`define CHUNKED_BODY_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chunked body decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define CBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chunked body decoder check failed");

`endif

// ===== hw/rtl/cbd_pkg.sv =====
// Types and constants shared by the chunked body decoder modules.
`timescale 1ns / 1ps
`default_nettype none
package cbd_pkg;

  localparam int SIZE_BITS = 32;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int TRAIL_W = 2;
  localparam logic [TRAIL_W-1:0] TRAIL_LEN = TRAIL_W'(2);

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_lf;
    logic       is_cr;
    logic       is_blank;
    logic       is_hex;
    logic [3:0] hex_val;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cbd_front.sv =====
// Front end: accepts raw body bytes and classifies each one for the back end.
`timescale 1ns / 1ps
`default_nettype none
module cbd_front (
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,
  input  wire logic         s_tuser,
  input  wire logic         q_full,
  output cbd_pkg::req_t     push
);

  logic [7:0] b;

  always_comb begin
    b = s_tdata;
    s_tready = !q_full;
    push.valid = s_tvalid && !q_full;
    push.item.data = b;
    push.item.start = s_tuser;
    push.item.is_lf = (b == cbd_pkg::CHAR_LF);
    push.item.is_cr = (b == cbd_pkg::CHAR_CR);
    push.item.is_blank = (b == cbd_pkg::CHAR_SPACE) || (b == cbd_pkg::CHAR_TAB) ||
                         (b == cbd_pkg::CHAR_VT) || (b == cbd_pkg::CHAR_FF) ||
                         (b == cbd_pkg::CHAR_CR);
    push.item.is_hex = 1'b0;
    push.item.hex_val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      push.item.is_hex = 1'b1;
      push.item.hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      push.item.is_hex = 1'b1;
      push.item.hex_val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      push.item.is_hex = 1'b1;
      push.item.hex_val = 4'(b - 8'h37);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cbd_queue.sv =====
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module cbd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cbd_pkg::req_t push,
  output logic               full,
  output cbd_pkg::req_t      head,
  input  wire logic          pop
);

  cbd_pkg::item_t slots [cbd_pkg::QDEPTH];
  logic [cbd_pkg::QPTR_W-1:0] wr_ptr;
  logic [cbd_pkg::QPTR_W-1:0] rd_ptr;
  logic [cbd_pkg::QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  always_comb begin
    full = (count == cbd_pkg::QCNT_W'(cbd_pkg::QDEPTH));
    head.valid = (count != '0);
    head.item = slots[rd_ptr];
    do_push = push.valid && !full;
    do_pop = pop && head.valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push.item;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cbd_back.sv =====
// Back end: runs the chunk state machine and holds the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "chunked_body_decoder_macros.svh"
module cbd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cbd_pkg::req_t head,
  output logic               pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [7:0]         m_tdata,
  output logic               m_tuser
);

  typedef enum logic [1:0] {PH_LINE, PH_DATA, PH_TRAIL, PH_DONE} phase_t;

  localparam int SB = cbd_pkg::SIZE_BITS;

  phase_t phase, phase_next;
  logic [SB-1:0] bytes_remaining, bytes_remaining_next;
  logic [SB-1:0] size_accum, size_accum_next;
  logic digit_seen, digit_seen_next;
  logic parse_stopped, parse_stopped_next;
  logic line_has_content, line_has_content_next;
  logic pending_cr, pending_cr_next;
  logic [cbd_pkg::TRAIL_W-1:0] trailer_left, trailer_left_next;

  phase_t ph;
  logic [SB-1:0] br, acc;
  logic ds, stp, cont, pcr, stp1, cont1, st;
  logic [cbd_pkg::TRAIL_W-1:0] tl;
  logic emit, emit_end;
  cbd_pkg::item_t it;

  always_comb begin
    it = head.item;
    pop = head.valid && (!m_tvalid || m_tready);
    st = it.start;
    ph = st ? PH_LINE : phase;
    br = st ? '0 : bytes_remaining;
    acc = st ? '0 : size_accum;
    ds = st ? 1'b0 : digit_seen;
    stp = st ? 1'b0 : parse_stopped;
    cont = st ? 1'b0 : line_has_content;
    pcr = st ? 1'b0 : pending_cr;
    tl = st ? '0 : trailer_left;
    stp1 = stp || (pcr && ds);
    cont1 = cont || pcr;

    phase_next = phase;
    bytes_remaining_next = bytes_remaining;
    size_accum_next = size_accum;
    digit_seen_next = digit_seen;
    parse_stopped_next = parse_stopped;
    line_has_content_next = line_has_content;
    pending_cr_next = pending_cr;
    trailer_left_next = trailer_left;
    emit = 1'b0;
    emit_end = 1'b0;

    if (pop) begin
      phase_next = ph;
      bytes_remaining_next = br;
      size_accum_next = acc;
      digit_seen_next = ds;
      parse_stopped_next = stp;
      line_has_content_next = cont;
      pending_cr_next = pcr;
      trailer_left_next = tl;
      unique case (ph)
        PH_LINE: begin
          if (it.is_lf) begin
            size_accum_next = '0;
            digit_seen_next = 1'b0;
            parse_stopped_next = 1'b0;
            line_has_content_next = 1'b0;
            pending_cr_next = 1'b0;
            if (cont && acc == '0) begin
              phase_next = PH_DONE;
              emit = 1'b1;
              emit_end = 1'b1;
            end else if (cont) begin
              bytes_remaining_next = acc;
              phase_next = PH_DATA;
            end
          end else begin
            pending_cr_next = it.is_cr;
            parse_stopped_next = stp1;
            line_has_content_next = cont1;
            if (!it.is_cr) begin
              line_has_content_next = 1'b1;
              if (!stp1) begin
                if (it.is_hex) begin
                  digit_seen_next = 1'b1;
                  if (|acc[SB-1:SB-4]) begin
                    size_accum_next = '1;
                  end else begin
                    size_accum_next = {acc[SB-5:0], it.hex_val};
                  end
                end else if (!(it.is_blank && !ds)) begin
                  parse_stopped_next = 1'b1;
                end
              end
            end
          end
        end
        PH_DATA: begin
          emit = 1'b1;
          bytes_remaining_next = br - 1'b1;
          if (br == SB'(1)) begin
            phase_next = PH_TRAIL;
            trailer_left_next = cbd_pkg::TRAIL_LEN;
          end
        end
        PH_TRAIL: begin
          if (tl != '0) begin
            trailer_left_next = tl - 1'b1;
          end
          if (tl <= cbd_pkg::TRAIL_W'(1)) begin
            phase_next = PH_LINE;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LINE;
      bytes_remaining <= '0;
      size_accum <= '0;
      digit_seen <= 1'b0;
      parse_stopped <= 1'b0;
      line_has_content <= 1'b0;
      pending_cr <= 1'b0;
      trailer_left <= '0;
      m_tvalid <= 1'b0;
    end else begin
      phase <= phase_next;
      bytes_remaining <= bytes_remaining_next;
      size_accum <= size_accum_next;
      digit_seen <= digit_seen_next;
      parse_stopped <= parse_stopped_next;
      line_has_content <= line_has_content_next;
      pending_cr <= pending_cr_next;
      trailer_left <= trailer_left_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (emit) begin
      m_tdata <= emit_end ? 8'd0 : it.data;
      m_tuser <= emit_end;
    end
  end

  `CBD_ASSERT_SAME(a_trailer_only_in_trail, clk, rst, trailer_left != '0, phase == PH_TRAIL)
  `CBD_ASSERT_SAME(a_data_has_bytes, clk, rst, phase == PH_DATA, bytes_remaining != '0)
  `CBD_ASSERT_NEXT(a_data_emits, clk, rst, pop && !it.start && phase == PH_DATA, m_tvalid)
  `CBD_ASSERT_SAME(a_done_is_quiet, clk, rst, pop && !it.start && phase == PH_DONE, !emit)

endmodule
`default_nettype wire

// ===== hw/rtl/chunked_body_decoder.sv =====
// Top level of the chunked transfer body decoder.
// Usage:
// The slave channel (s_tvalid, s_tready, s_tdata, s_tuser) takes one raw byte of a
// chunked body per request; s_tuser high clears the decoder before that byte is used.
// The master channel (m_tvalid, m_tready, m_tdata, m_tuser) returns decoded payload
// bytes, and at most once per message a request with m_tuser high and m_tdata zero that
// marks the end of the body. Size lines, blank lines and chunk trailers give no request.
// Throughput is one byte per cycle while the receiver does not stall, set by the back
// end's state update, which does one wide add and compare per byte.
// An accepted input passes through the four-entry queue and the output register before
// any result that it gives reaches the master side.
// When the receiver stalls, the output register holds its request, the back end stops
// and the queue fills; s_tready falls only when the queue is full.
// Reset clears the queue, the output valid flag and all decoder state; the block accepts
// bytes in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module chunked_body_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tuser,   // [0] start_of_message
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tuser    // [0] end_of_body
);

  cbd_pkg::req_t push;
  cbd_pkg::req_t head;
  logic q_full;
  logic pop;

  cbd_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push)
  );

  cbd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  cbd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the chunked body decoder: random streams and idle patterns.
`timescale 1ns / 1ps
module tb;
  import cbd_pkg::*;

  typedef enum logic [1:0] {SIZE_LINE, CHUNK_DATA, CHUNK_TRAILER, BODY_DONE} dec_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } raw_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } decoded_t;

  localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;
  localparam int PHASES = 4;
  localparam int ITEMS_PER_PHASE = 412;
  localparam int SETTLE_CYCLES = 10;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;

  raw_byte_t   byte_q[$];
  decoded_t    decoded_q[$];
  bit          new_msg;
  int unsigned pushed_cnt, accepted_cnt, counted_items, msg_cnt;
  int unsigned payload_seen, ends_seen, err_cnt;
  int unsigned send_idle_pct, recv_stall_pct;

  dec_phase_e             dec_phase;
  logic [SIZE_BITS-1:0]   remaining;
  logic [SIZE_BITS-1:0]   size_acc;
  logic                   digit_seen, parse_stopped, line_nonempty, cr_held;
  logic [TRAIL_W-1:0]     trailer_left;

  chunked_body_decoder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #1 clk = ~clk;

  task automatic flag_error(input string msg);
    err_cnt++;
    $display("tb: mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - 8'h30);
    if (c >= "a" && c <= "f") return int'(c - 8'h61) + 10;
    if (c >= "A" && c <= "F") return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF || c == CHAR_CR;
  endfunction

  task automatic clear_line();
    size_acc = '0;
    digit_seen = 1'b0;
    parse_stopped = 1'b0;
    line_nonempty = 1'b0;
    cr_held = 1'b0;
  endtask

  task automatic reset_decoder();
    dec_phase = SIZE_LINE;
    remaining = '0;
    trailer_left = '0;
    clear_line();
  endtask

  task automatic absorb_char(input logic [7:0] c);
    int d;
    line_nonempty = 1'b1;
    if (parse_stopped) return;
    d = hex_digit(c);
    if (d >= 0) begin
      digit_seen = 1'b1;
      if (size_acc > (SIZE_MAX >> 4)) size_acc = SIZE_MAX;
      else size_acc = {size_acc[SIZE_BITS-5:0], d[3:0]};
    end else if (!(is_blank(c) && !digit_seen)) begin
      parse_stopped = 1'b1;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic start);
    if (start) reset_decoder();
    case (dec_phase)
      SIZE_LINE: begin
        if (b == CHAR_LF) begin
          if (!line_nonempty) begin
            clear_line();
          end else if (size_acc == '0) begin
            dec_phase = BODY_DONE;
            clear_line();
            decoded_q.push_back('{data: 8'h00, eob: 1'b1});
          end else begin
            remaining = size_acc;
            dec_phase = CHUNK_DATA;
            clear_line();
          end
        end else begin
          if (cr_held) begin
            cr_held = 1'b0;
            absorb_char(CHAR_CR);
          end
          if (b == CHAR_CR) cr_held = 1'b1;
          else absorb_char(b);
        end
      end
      CHUNK_DATA: begin
        remaining = remaining - 1'b1;
        if (remaining == '0) begin
          dec_phase = CHUNK_TRAILER;
          trailer_left = TRAIL_LEN;
        end
        decoded_q.push_back('{data: b, eob: 1'b0});
      end
      CHUNK_TRAILER: begin
        if (trailer_left > 0) trailer_left = trailer_left - 1'b1;
        if (trailer_left == 0) dec_phase = SIZE_LINE;
      end
      default: ;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input bit counted = 1'b1);
    raw_byte_t r;
    r.data = b;
    r.start = new_msg;
    new_msg = 1'b0;
    byte_q.push_back(r);
    pushed_cnt++;
    if (counted) counted_items++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  function automatic logic [7:0] blank_pick();
    case ($urandom_range(0, 4))
      0: return CHAR_SPACE;
      1: return CHAR_TAB;
      2: return CHAR_VT;
      3: return CHAR_FF;
      default: return CHAR_CR;
    endcase
  endfunction

  task automatic push_size_line(input logic [31:0] n, input int lead_zeros);
    int nd;
    logic [7:0] c;
    nd = 1;
    while (nd < 8 && (n >> (4 * nd)) != 0) nd++;
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) push_byte(blank_pick());
    repeat (lead_zeros) push_byte("0");
    for (int i = nd - 1; i >= 0; i--) push_byte(hex_char(n[4*i +: 4]));
    case ($urandom_range(0, 7))
      0: begin
        push_byte(";");
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(33, 126)));
      end
      1: push_byte(blank_pick());
      2: begin
        c = 8'($urandom_range(0, 255));
        push_byte(c == CHAR_LF ? 8'h67 : c);
      end
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      push_byte(CHAR_LF);
    end else begin
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
    end
  endtask

  task automatic gen_message();
    int unsigned pick, n;
    pick = $urandom_range(0, 99);
    new_msg = 1'b1;
    msg_cnt++;
    if (pick < 80) begin
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 5) == 0) push_byte(CHAR_LF);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        push_size_line(n, $urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : 0);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0) begin
          repeat (2) push_byte(8'($urandom_range(0, 255)));
        end else begin
          push_byte(CHAR_CR);
          push_byte(CHAR_LF);
        end
      end
      push_size_line(0, $urandom_range(0, 2));
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 84) begin
      // A size too wide for the counter saturates; the next message cuts the chunk short.
      push_byte(hex_char(4'($urandom_range(1, 15))));
      repeat ($urandom_range(8, 11)) push_byte(hex_char(4'($urandom_range(0, 15))));
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(4, 24)) begin
        if ($urandom_range(0, 39) == 0) new_msg = 1'b1;
        case ($urandom_range(0, 5))
          0: push_byte(hex_char(4'($urandom_range(0, 15))));
          1: push_byte(blank_pick());
          2: push_byte(CHAR_CR);
          3: push_byte(CHAR_LF);
          default: push_byte(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    raw_byte_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'h00;
      s_tuser <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || s_tready) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = byte_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nxt.data;
          s_tuser <= nxt.start;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      reset_decoder();
    end else begin
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata, s_tuser);
        accepted_cnt++;
      end
      if (m_tvalid && m_tready) begin
        if (decoded_q.size() == 0) begin
          flag_error($sformatf("unexpected request data=%02h end=%0b", m_tdata, m_tuser));
        end else begin
          want = decoded_q.pop_front();
          if (m_tuser !== want.eob)
            flag_error($sformatf("end_of_body %0b, expected %0b", m_tuser, want.eob));
          if (m_tdata !== want.data)
            flag_error($sformatf("out_byte %02h, expected %02h", m_tdata, want.data));
          if (want.eob) ends_seen++;
          else payload_seen++;
        end
      end
    end
  end

  initial begin
    int unsigned send_pct[PHASES] = '{0, 45, 0, 24};
    int unsigned recv_pct[PHASES] = '{0, 0, 45, 24};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      if (ph == 0) begin
        new_msg = 1'b1;
        msg_cnt++;
        push_byte(" "); push_byte("2"); push_byte(";"); push_byte(CHAR_CR); push_byte(CHAR_LF);
        push_byte(8'h00); push_byte(8'hFF); push_byte(CHAR_CR); push_byte(CHAR_LF);
        push_byte(CHAR_LF);
        push_byte(CHAR_CR); push_byte("1"); push_byte(CHAR_CR); push_byte("x"); push_byte(CHAR_LF);
        push_byte(CHAR_LF); push_byte("a"); push_byte("b");
        push_byte("0"); push_byte(CHAR_LF);
        push_byte(8'h33, 1'b0);
        new_msg = 1'b1;
        msg_cnt++;
        push_byte("g"); push_byte(CHAR_LF);
      end
      while (counted_items < (ph + 1) * ITEMS_PER_PHASE) gen_message();
      while (accepted_cnt != pushed_cnt) @(posedge clk);
    end
    while (decoded_q.size() != 0) @(posedge clk);
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d raw bytes in %0d messages under four idle patterns,", accepted_cnt,
             msg_cnt);
    $display("tb: %0d payload bytes and %0d end markers compared", payload_seen, ends_seen);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== chunked_body_decoder.f =====
+incdir+hw/rtl
hw/rtl/cbd_pkg.sv
hw/rtl/cbd_front.sv
hw/rtl/cbd_queue.sv
hw/rtl/cbd_back.sv
hw/rtl/chunked_body_decoder.sv
verif/tb.sv
